[rtl/core/urft_pkg.sv]
// Shared types and constants for the UART receive FIFO with idle timeout.
`default_nettype none

package urft_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_BYTE  = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_FLUSH = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_ALMOST_FULL  = 2'd1;

	// Field widths and reset values
	localparam int BYTE_W      = 8;
	localparam int COUNT_W     = 11;
	localparam int READ_W      = 7;
	localparam int CFG_INDEX_W = 2;
	localparam logic [7:0]  IDLE_TIMEOUT_RST = 8'd1;
	localparam logic [10:0] ALMOST_FULL_RST  = 11'd614;
	localparam logic [7:0]  IDLE_MAX         = 8'd255;

	// Input word
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic       rx_error;
		logic [6:0] read_count;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [7:0]  rd_data;
		logic        rd_valid;
		logic        last_of_run;
		logic        event_received;
		logic        event_overflow;
		logic [10:0] unread_count;
	} out_word_t;

	// Operation request to the shared pointer and count unit
	typedef struct packed {
		logic cnt_up;
		logic cnt_dn;
	} step_op_t;

endpackage

`default_nettype wire

[rtl/core/urft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/urft_step.sv]
// Shared pointer-advance and fill-count unit used by both push and pop.
`default_nettype none

module urft_step #(
	parameter int DEPTH = 1024
) (
	input  wire logic                       [$clog2(DEPTH)-1:0]   ptr_in,
	input  wire logic                       [$clog2(DEPTH+1)-1:0] cnt_in,
	input  wire urft_pkg::step_op_t                               op,
	output logic                            [$clog2(DEPTH)-1:0]   ptr_next,
	output logic                            [$clog2(DEPTH+1)-1:0] cnt_next
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Advance pointer with wrap at the ring size
	always_comb begin
		if (ptr_in == AW'(DEPTH - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = ptr_in + AW'(1);
		end
	end

	// Bump or drop the fill count
	always_comb begin
		if (op.cnt_up) begin
			cnt_next = cnt_in + CW'(1);
		end else if (op.cnt_dn) begin
			cnt_next = cnt_in - CW'(1);
		end else begin
			cnt_next = cnt_in;
		end
	end

endmodule

`default_nettype wire

[rtl/core/uart_rx_fifo_idle_timeout_unit.sv]
// Top level: UART receive FIFO with idle-character timeout and its sequencer.
//
// Usage: requests arrive on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data. A received byte, a tick or a flush
// produces one result word, loaded into the output register at the
// accepting edge. A read pops min(read_count, MAX_READ, unread) bytes;
// for each popped byte the sequencer first issues the buffer RAM read
// (S_RD_ADDR), then takes the registered read data into the output
// register (S_RD_DATA). The shared pointer/count unit and the single
// RAM read port set this order. A read that pops nothing gives one
// status word. in_ready is high only while the sequencer is idle and the
// output register is empty or being drained.
// A stalled receiver holds out_data steady and stops the sequencer before it loads the next result.
// Reset clears pointers, fill count, timer state and registers to their
// reset values; the buffer contents are not cleared and need no sweep.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once
// and are expected only while the block is idle.
`default_nettype none

module uart_rx_fifo_idle_timeout_unit #(
	parameter int DEPTH    = 1024,
	parameter int MAX_READ = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire urft_pkg::in_word_t                      in_data,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output urft_pkg::out_word_t                          out_data,
	input  wire logic                                    cfg_we,
	input  wire logic [urft_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [urft_pkg::COUNT_W-1:0]            cfg_data
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int RW   = urft_pkg::READ_W;
	localparam int MW   = (CW > urft_pkg::COUNT_W) ? CW : urft_pkg::COUNT_W;
	localparam int NW   = (CW > RW) ? CW : RW;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_RD_ADDR = 2'd1;
	localparam logic [1:0] S_RD_DATA = 2'd2;

	logic [1:0]                      state_q;
	logic [AW-1:0]                   rd_ptr_q;
	logic [AW-1:0]                   wr_ptr_q;
	logic [CW-1:0]                   count_q;
	logic [7:0]                      idle_q;
	logic                            seen_q;
	logic                            running_q;
	logic [7:0]                      timeout_q;
	logic [urft_pkg::COUNT_W-1:0]    mark_q;
	logic [RW-1:0]                   remain_q;
	logic                            ov_q;
	urft_pkg::out_word_t             od_q;

	logic                            out_free;
	logic                            accept;
	logic                            full;
	logic                            push;
	logic                            pop;
	logic [RW-1:0]                   sat_n;
	logic [RW-1:0]                   pop_n;
	logic [7:0]                      idle_nx;
	logic                            fire;
	logic [AW-1:0]                   step_ptr;
	logic [AW-1:0]                   ptr_next;
	logic [CW-1:0]                   cnt_next;
	urft_pkg::step_op_t              step_op;
	logic [urft_pkg::BYTE_W-1:0]     ram_rdata;
	logic [urft_pkg::COUNT_W-1:0]    count_out;

	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign push      = accept && (in_data.req_type == urft_pkg::REQ_BYTE)
		&& !in_data.rx_error && !full;
	assign pop       = (state_q == S_RD_ADDR);
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign count_out = urft_pkg::COUNT_W'(count_q);

	// Clamp the read length to MAX_READ and to the bytes held
	always_comb begin
		if (in_data.read_count > RW'(MAX_READ)) begin
			sat_n = RW'(MAX_READ);
		end else begin
			sat_n = in_data.read_count;
		end
		if (NW'(sat_n) > NW'(count_q)) begin
			pop_n = RW'(count_q);
		end else begin
			pop_n = sat_n;
		end
	end

	// Work out the idle count and the received event for a tick
	always_comb begin
		if (seen_q) begin
			idle_nx = '0;
		end else if (idle_q < urft_pkg::IDLE_MAX) begin
			idle_nx = idle_q + 8'd1;
		end else begin
			idle_nx = idle_q;
		end
		fire = running_q && ((idle_nx >= timeout_q) || (MW'(count_q) == MW'(mark_q)));
	end

	// Steer the shared unit to the pointer in use this cycle
	assign step_ptr       = pop ? rd_ptr_q : wr_ptr_q;
	assign step_op.cnt_up = push;
	assign step_op.cnt_dn = pop;

	urft_step #(
		.DEPTH(DEPTH)
	) u_step (
		.ptr_in  (step_ptr),
		.cnt_in  (count_q),
		.op      (step_op),
		.ptr_next(ptr_next),
		.cnt_next(cnt_next)
	);

	urft_ram #(
		.WIDTH(urft_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wr_ptr_q),
		.wdata(in_data.rx_byte),
		.re   (pop),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= urft_pkg::IDLE_TIMEOUT_RST;
			mark_q    <= urft_pkg::ALMOST_FULL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				urft_pkg::REG_IDLE_TIMEOUT: timeout_q <= cfg_data[7:0];
				urft_pkg::REG_ALMOST_FULL:  mark_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequence requests, update buffer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			idle_q    <= '0;
			seen_q    <= 1'b0;
			running_q <= 1'b0;
			remain_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_data.req_type)
							urft_pkg::REQ_BYTE: begin
								if (!in_data.rx_error) begin
									seen_q <= 1'b1;
									if (!running_q) begin
										idle_q    <= '0;
										running_q <= 1'b1;
									end
								end
								if (push) begin
									wr_ptr_q <= ptr_next;
									count_q  <= cnt_next;
								end
							end
							urft_pkg::REQ_TICK: begin
								if (running_q) begin
									seen_q <= 1'b0;
									idle_q <= idle_nx;
									if (fire) begin
										running_q <= 1'b0;
									end
								end
							end
							urft_pkg::REQ_READ: begin
								remain_q <= pop_n;
								if (pop_n != '0) begin
									state_q <= S_RD_ADDR;
								end
							end
							urft_pkg::REQ_FLUSH: begin
								rd_ptr_q <= '0;
								wr_ptr_q <= '0;
								count_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_RD_ADDR: begin
					rd_ptr_q <= ptr_next;
					count_q  <= cnt_next;
					remain_q <= remain_q - RW'(1);
					state_q  <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						state_q <= (remain_q == '0) ? S_IDLE : S_RD_ADDR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (accept && !((in_data.req_type == urft_pkg::REQ_READ) && (pop_n != '0))) begin
			ov_q <= 1'b1;
		end else if ((state_q == S_RD_DATA) && out_free) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// Build the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			od_q.rd_data        <= '0;
			od_q.rd_valid       <= 1'b0;
			od_q.last_of_run    <= 1'b1;
			od_q.event_received <= (in_data.req_type == urft_pkg::REQ_TICK) && fire;
			od_q.event_overflow <= (in_data.req_type == urft_pkg::REQ_BYTE)
				&& !in_data.rx_error && full;
			if (in_data.req_type == urft_pkg::REQ_FLUSH) begin
				od_q.unread_count <= '0;
			end else if (push) begin
				od_q.unread_count <= urft_pkg::COUNT_W'(cnt_next);
			end else begin
				od_q.unread_count <= count_out;
			end
		end else if ((state_q == S_RD_DATA) && out_free) begin
			od_q.rd_data        <= ram_rdata;
			od_q.rd_valid       <= 1'b1;
			od_q.last_of_run    <= (remain_q == '0);
			od_q.event_received <= 1'b0;
			od_q.event_overflow <= 1'b0;
			od_q.unread_count   <= count_out;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above buffer depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_ADDR) |-> (count_q != '0))
		else $error("pop issued on an empty buffer");

	a_last_pop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RD_DATA) && out_free && (remain_q == '0))
		|=> ((state_q == S_IDLE) && out_data.last_of_run && out_data.rd_valid))
		else $error("final popped byte not marked last");
`endif

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the UART receive FIFO with idle timeout: directed and random traffic.

module tb_top;
	import urft_pkg::*;

	localparam int FIFO_DEPTH    = 1024;
	localparam int MAX_POP       = 64;
	localparam int RANDOM_ITEMS  = 480;
	localparam int MAX_REPORTS   = 10;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 6000000;
	localparam int IN_W          = $bits(in_word_t);

	// Register indexes that hit no register; the block must ignore them
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_word_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_word_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0]     cfg_data = '0;

	// Shadow copy of the FIFO, timer and registers
	logic [7:0]  shadow_store [FIFO_DEPTH];
	logic [9:0]  shadow_rd = '0;
	logic [9:0]  shadow_wr = '0;
	logic [10:0] shadow_held = '0;
	logic [7:0]  shadow_idle = '0;
	logic        shadow_heard = 1'b0;
	logic        shadow_timer_on = 1'b0;
	logic [7:0]  cfg_timeout = IDLE_TIMEOUT_RST;
	logic [10:0] cfg_mark = ALMOST_FULL_RST;

	out_word_t   fifo_words_due [$];
	out_word_t   due_word;
	int unsigned bad_words = 0;
	int unsigned words_sent = 0;
	int unsigned burst_left = 1;
	int unsigned sink_hold = 0;
	int unsigned cycle_cnt = 0;

	uart_rx_fifo_idle_timeout_unit #(
		.DEPTH(FIFO_DEPTH),
		.MAX_READ(MAX_POP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Alternate short stalls with ready stretches, some of them long
	always @(negedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (out_ready && $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b0;
			sink_hold <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
			sink_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
				: $urandom_range(0, 10);
		end
	end

	// Compare each accepted result word with the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (fifo_words_due.size() == 0) begin
				bad_words++;
				if (bad_words <= MAX_REPORTS)
					$display("cycle %0d: result word %h with none due", cycle_cnt, out_data);
			end else begin
				due_word = fifo_words_due.pop_front();
				if (out_data !== due_word) begin
					bad_words++;
					if (bad_words <= MAX_REPORTS) begin
						$display("cycle %0d: expected data %h valid %b last %b rcv %b ovf %b count %0d",
							cycle_cnt, due_word.rd_data, due_word.rd_valid, due_word.last_of_run,
							due_word.event_received, due_word.event_overflow,
							due_word.unread_count);
						$display("cycle %0d: got      data %h valid %b last %b rcv %b ovf %b count %0d",
							cycle_cnt, out_data.rd_data, out_data.rd_valid, out_data.last_of_run,
							out_data.event_received, out_data.event_overflow,
							out_data.unread_count);
					end
				end
			end
		end
	end

	function automatic in_word_t make_word(logic [1:0] req, logic [7:0] data, logic err,
		logic [6:0] cnt);
		in_word_t w;
		w.req_type   = req;
		w.rx_byte    = data;
		w.rx_error   = err;
		w.read_count = cnt;
		return w;
	endfunction

	// Queue one result word; the count is the shadow fill at this point
	task automatic queue_word(logic [7:0] data, logic valid, logic last, logic ev_rx,
		logic ev_ovf);
		out_word_t r;
		r.rd_data        = data;
		r.rd_valid       = valid;
		r.last_of_run    = last;
		r.event_received = ev_rx;
		r.event_overflow = ev_ovf;
		r.unread_count   = shadow_held;
		fifo_words_due.push_back(r);
	endtask

	// Advance the shadow FIFO by one accepted word and queue what it yields
	task automatic advance_fifo(in_word_t w);
		logic ovf;
		logic fired;
		int   n;
		case (w.req_type)
			REQ_BYTE: begin
				ovf = 1'b0;
				if (!w.rx_error) begin
					shadow_heard = 1'b1;
					if (!shadow_timer_on) begin
						shadow_idle     = '0;
						shadow_timer_on = 1'b1;
					end
					if (shadow_held < FIFO_DEPTH) begin
						shadow_store[shadow_wr] = w.rx_byte;
						shadow_wr++;
						shadow_held++;
					end else begin
						ovf = 1'b1;
					end
				end
				queue_word(8'h00, 1'b0, 1'b1, 1'b0, ovf);
			end
			REQ_TICK: begin
				fired = 1'b0;
				if (shadow_timer_on) begin
					if (shadow_heard) begin
						shadow_heard = 1'b0;
						shadow_idle  = '0;
					end else if (shadow_idle != IDLE_MAX) begin
						shadow_idle++;
					end
					if (shadow_idle >= cfg_timeout || shadow_held == cfg_mark) begin
						shadow_timer_on = 1'b0;
						fired           = 1'b1;
					end
				end
				queue_word(8'h00, 1'b0, 1'b1, fired, 1'b0);
			end
			REQ_READ: begin
				n = (w.read_count > MAX_POP) ? MAX_POP : w.read_count;
				if (n > shadow_held)
					n = shadow_held;
				if (n == 0)
					queue_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
				for (int i = 0; i < n; i++) begin
					shadow_rd++;
					shadow_held--;
					queue_word(shadow_store[shadow_rd - 10'd1], 1'b1, i == n - 1, 1'b0, 1'b0);
				end
			end
			default: begin
				shadow_rd   = '0;
				shadow_wr   = '0;
				shadow_held = '0;
				queue_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
			end
		endcase
	endtask

	// Offer one word, hold it until taken, then maybe pause between bursts
	task automatic send_word(in_word_t w);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		advance_fifo(w);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 12);
		end
	endtask

	// Hold the sender until every due word is back and the block has settled
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (fifo_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IDLE_TIMEOUT: cfg_timeout = value[7:0];
			REG_ALMOST_FULL:  cfg_mark = value;
			default: ;
		endcase
	endtask

	// Reset settings: dropped bytes, idle ticks, read limits
	task automatic test_basic_traffic();
		send_word(make_word(REQ_TICK, 8'hFF, 1'b1, 7'd127));
		send_word(make_word(REQ_BYTE, 8'hFF, 1'b1, 7'd0));
		send_word(make_word(REQ_BYTE, 8'h00, 1'b0, 7'd127));
		send_word(make_word(REQ_BYTE, 8'hFF, 1'b0, 7'd0));
		send_word(make_word(REQ_TICK, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_TICK, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_TICK, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_READ, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_READ, 8'hFF, 1'b1, 7'd1));
		send_word(make_word(REQ_READ, 8'h00, 1'b0, 7'd127));
		send_word(make_word(REQ_READ, 8'h00, 1'b0, 7'd5));
	endtask

	// Zero timeout, zero mark, flush under a running timer, unused indexes
	task automatic test_flush_and_marks();
		wait_drained();
		write_reg(REG_IDLE_TIMEOUT, 11'd0);
		write_reg(REG_ALMOST_FULL, 11'd0);
		send_word(make_word(REQ_BYTE, 8'hA5, 1'b0, 7'd64));
		send_word(make_word(REQ_FLUSH, 8'h5A, 1'b1, 7'd3));
		send_word(make_word(REQ_TICK, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_BYTE, 8'h5A, 1'b0, 7'd0));
		send_word(make_word(REQ_TICK, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_FLUSH, 8'h00, 1'b0, 7'd0));
		wait_drained();
		write_reg(REG_IDLE_TIMEOUT, {3'b111, 8'd200});
		write_reg(REG_ALMOST_FULL, 11'd3);
		write_reg(REG_SPARE_LO, 11'h7FF);
		write_reg(REG_SPARE_HI, 11'h7FF);
		send_word(make_word(REQ_BYTE, 8'h3C, 1'b0, 7'd0));
		send_word(make_word(REQ_BYTE, 8'hC3, 1'b0, 7'd0));
		send_word(make_word(REQ_BYTE, 8'h81, 1'b0, 7'd0));
		send_word(make_word(REQ_TICK, 8'h00, 1'b0, 7'd0));
		send_word(make_word(REQ_READ, 8'h00, 1'b0, 7'd64));
		send_word(make_word(REQ_FLUSH, 8'h00, 1'b0, 7'd0));
	endtask

	// Longest timeout: idle count climbs to its ceiling before firing
	task automatic test_idle_saturation();
		wait_drained();
		write_reg(REG_IDLE_TIMEOUT, 11'd255);
		write_reg(REG_ALMOST_FULL, 11'h7FF);
		send_word(make_word(REQ_BYTE, 8'($urandom), 1'b0, 7'($urandom)));
		repeat (260)
			send_word(make_word(REQ_TICK, 8'($urandom), 1'($urandom), 7'($urandom)));
		send_word(make_word(REQ_READ, 8'($urandom), 1'($urandom), 7'd64));
	endtask

	// Fill past capacity across the ring wrap, fire at a full mark, drain
	task automatic test_overflow();
		wait_drained();
		write_reg(REG_ALMOST_FULL, COUNT_W'(FIFO_DEPTH));
		repeat (FIFO_DEPTH + 3)
			send_word(make_word(REQ_BYTE, 8'($urandom), 1'b0, 7'($urandom)));
		send_word(make_word(REQ_TICK, 8'($urandom), 1'($urandom), 7'($urandom)));
		repeat (17)
			send_word(make_word(REQ_READ, 8'($urandom), 1'($urandom),
				7'($urandom_range(64, 127))));
	endtask

	// Random messages under changing settings, mixed with noise
	task automatic test_random_traffic();
		int unsigned             start;
		int unsigned             next_cfg;
		int unsigned             pick;
		logic [7:0]              timeout;
		logic [10:0]             mark;
		logic [IN_W-1:0]         raw;
		start    = words_sent;
		next_cfg = 0;
		while (words_sent - start < RANDOM_ITEMS) begin
			if (words_sent - start >= next_cfg) begin
				wait_drained();
				case ($urandom_range(0, 3))
					0: timeout = 8'd0;
					1: timeout = 8'($urandom_range(1, 3));
					2: timeout = 8'($urandom_range(4, 8));
					default: timeout = 8'd255;
				endcase
				case ($urandom_range(0, 4))
					0: mark = 11'd0;
					1: mark = COUNT_W'(FIFO_DEPTH);
					2: mark = 11'h7FF;
					3: mark = 11'($urandom);
					default: mark = 11'($urandom_range(1, 40));
				endcase
				write_reg(REG_IDLE_TIMEOUT, {3'($urandom), timeout});
				write_reg(REG_ALMOST_FULL, mark);
				next_cfg += 120;
			end
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				// well-formed message: bytes, idle ticks, then read it out
				repeat ($urandom_range(1, 24))
					send_word(make_word(REQ_BYTE, 8'($urandom), $urandom_range(0, 15) == 0,
						7'($urandom)));
				repeat ($urandom_range(1, 8))
					send_word(make_word(REQ_TICK, 8'($urandom), 1'($urandom), 7'($urandom)));
				if ($urandom_range(0, 3) != 0)
					send_word(make_word(REQ_READ, 8'($urandom), 1'($urandom),
						7'($urandom_range(1, 64))));
			end else if (pick < 17) begin
				send_word(make_word(REQ_READ, 8'($urandom), 1'($urandom),
					7'($urandom_range(0, 127))));
			end else if (pick < 19) begin
				raw = IN_W'($urandom);
				send_word(in_word_t'(raw));
			end else begin
				send_word(make_word(REQ_FLUSH, 8'($urandom), 1'($urandom), 7'($urandom)));
			end
		end
	endtask

	initial begin
		burst_left = $urandom_range(1, 12);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_basic_traffic();
		test_flush_and_marks();
		test_idle_saturation();
		test_overflow();
		test_random_traffic();
		wait_drained();
		repeat (16) @(posedge clk);
		if (bad_words == 0 && fifo_words_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
